FILE: sv/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// shared types, constants and helpers of the leaky integrate-and-fire tick core
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int NEURON_W    = 10;
  localparam int Q_W         = 32;
  localparam int POIS_W      = 8;
  localparam int REF_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = 2 * Q_W;
  localparam int POIS_PROD_W = Q_W + POIS_W + 1;
  localparam int SUM_W       = PROD_W + 2;

  localparam int NEURONS_DEF   = 1024;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_MEM   = 3'd0,
    CFG_GAIN_CUR    = 3'd1,
    CFG_GAIN_DC     = 3'd2,
    CFG_THRESHOLD   = 3'd3,
    CFG_REFRACT     = 3'd4,
    CFG_DECAY_CUR   = 3'd5,
    CFG_POIS_WEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    q_t               decay_membrane;
    q_t               gain_current;
    q_t               gain_dc;
    q_t               threshold;
    logic [REF_W-1:0] refractory_ticks;
    q_t               decay_current;
    q_t               poisson_weight;
  } cfg_t;

  // one word of the per-neuron state memory
  typedef struct packed {
    q_t               membrane;
    q_t               syn_current;
    logic [REF_W-1:0] refract_left;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  // product stage to update stage
  typedef struct packed {
    op_e                            op;
    logic [NEURON_W-1:0]            neuron;
    logic                           in_range;
    state_t                         old;
    logic signed [PROD_W-1:0]       p_mem;
    logic signed [PROD_W-1:0]       p_dc;
    logic signed [PROD_W-1:0]       p_cur;
    logic signed [PROD_W-1:0]       p_cdec;
    logic signed [POIS_PROD_W-1:0]  p_pois;
    q_t                             spike_current;
    q_t                             init_value;
  } prod_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic q_t sat_q(logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(Q_MAX)) begin
      return Q_MAX;
    end
    if (v < SUM_W'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(v[Q_W-1:0]);
  endfunction

endpackage

FILE: sv/lif_neuron_tick_update_core.sv
// ----------------------------------------------------------------------------
// lif_neuron_tick_update_core
// leaky integrate-and-fire tick and membrane load for one neuron per item
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   op_i neuron_i dc_drive_i poisson_in_i
//                                    spike_current_i init_value_i
//   out      out_valid_o/out_ready_i neuron_out_o spiked_o membrane_out_o
//   cfg      cfg_we_i (no wait)      cfg_idx_i cfg_wdata_i
//
// one item per cycle while the output is not stalled and each item names a neuron
// other than the two before it; results pass state read, product and update
// an item whose neuron is still in the product or update stage waits for that
// write, which is held off while the output stalls
// after reset a clear sweep writes zero to all NEURONS entries, one a cycle,
// with in_ready_o low until the sweep ends; config writes are taken throughout
// a stalled output holds; up to three items are in flight
// ----------------------------------------------------------------------------
module lif_neuron_tick_update_core import lif_pkg::*; #(
  parameter int NEURONS   = NEURONS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [NEURON_W-1:0]   neuron_i,
  input  logic signed [Q_W-1:0] dc_drive_i,
  input  logic [POIS_W-1:0]     poisson_in_i,
  input  logic signed [Q_W-1:0] spike_current_i,
  input  logic signed [Q_W-1:0] init_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NEURON_W-1:0]   neuron_out_o,
  output logic                  spiked_o,
  output logic signed [Q_W-1:0] membrane_out_o
);

  localparam int AW = addr_w(NEURONS);

  cfg_t                cfg_q;
  logic                clr_busy_q;
  logic [AW-1:0]       clr_addr_q;
  logic                s1_valid_q;
  logic                s2_valid_q;
  logic                out_valid_q;
  op_e                 s1_op_q;
  logic [NEURON_W-1:0] s1_neuron_q;
  logic                s1_in_range_q;
  q_t                  s1_dc_q;
  logic [POIS_W-1:0]   s1_pois_q;
  q_t                  s1_scur_q;
  q_t                  s1_init_q;

  logic                in_xfer;
  logic                out_adv;
  logic                s2_free;
  logic                s1_adv;
  logic                s1_free;
  logic                hazard;
  logic [STATE_W-1:0]  rd_data;
  state_t              rd_state;
  prod_t               prod;
  logic                upd_wr_en;
  state_t              upd_state;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [STATE_W-1:0]  ram_wdata;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DECAY_MEM:   cfg_q.decay_membrane   <= q_t'(cfg_wdata_i);
        CFG_GAIN_CUR:    cfg_q.gain_current     <= q_t'(cfg_wdata_i);
        CFG_GAIN_DC:     cfg_q.gain_dc          <= q_t'(cfg_wdata_i);
        CFG_THRESHOLD:   cfg_q.threshold        <= q_t'(cfg_wdata_i);
        CFG_REFRACT:     cfg_q.refractory_ticks <= cfg_wdata_i[REF_W-1:0];
        CFG_DECAY_CUR:   cfg_q.decay_current    <= q_t'(cfg_wdata_i);
        CFG_POIS_WEIGHT: cfg_q.poisson_weight   <= q_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_adv = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s2_free = !s2_valid_q || out_adv;
  assign s1_adv  = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_adv;
  // same neuron must not be read before its pending write lands
  assign hazard  = (s1_valid_q && (s1_neuron_q == neuron_i))
                || (s2_valid_q && (prod.neuron == neuron_i));

  assign in_ready_o = !clr_busy_q && s1_free && !hazard;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q       <= op_e'(op_i);
      s1_neuron_q   <= neuron_i;
      s1_in_range_q <= int'(neuron_i) < NEURONS;
      s1_dc_q       <= dc_drive_i;
      s1_pois_q     <= poisson_in_i;
      s1_scur_q     <= spike_current_i;
      s1_init_q     <= init_value_i;
    end
  end

  // clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(NEURONS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  assign ram_we    = clr_busy_q || (out_adv && upd_wr_en);
  assign ram_waddr = clr_busy_q ? clr_addr_q : AW'(prod.neuron);
  assign ram_wdata = clr_busy_q ? '0 : upd_state;

  lif_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NEURONS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (AW'(neuron_i)),
    .rdata_o (rd_data)
  );

  assign rd_state = state_t'(rd_data);

  lif_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i           (clk_i),
    .en_i            (s1_adv),
    .op_i            (s1_op_q),
    .neuron_i        (s1_neuron_q),
    .in_range_i      (s1_in_range_q),
    .dc_drive_i      (s1_dc_q),
    .poisson_in_i    (s1_pois_q),
    .spike_current_i (s1_scur_q),
    .init_value_i    (s1_init_q),
    .old_i           (rd_state),
    .cfg_i           (cfg_q),
    .prod_o          (prod)
  );

  lif_upd u_upd (
    .clk_i          (clk_i),
    .en_i           (out_adv),
    .prod_i         (prod),
    .cfg_i          (cfg_q),
    .wr_en_o        (upd_wr_en),
    .wr_state_o     (upd_state),
    .neuron_out_o   (neuron_out_o),
    .spiked_o       (spiked_o),
    .membrane_out_o (membrane_out_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/lif_ram.sv
// ----------------------------------------------------------------------------
// lif_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lif_ram import lif_pkg::*; #(
  parameter int WIDTH = STATE_W,
  parameter int DEPTH = NEURONS_DEF
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [addr_w(DEPTH)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [addr_w(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lif_mul.sv
// ----------------------------------------------------------------------------
// lif_mul
// product stage: forms all fixed-point products of one item and registers them
// ----------------------------------------------------------------------------
module lif_mul import lif_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  op_e                 op_i,
  input  logic [NEURON_W-1:0] neuron_i,
  input  logic                in_range_i,
  input  q_t                  dc_drive_i,
  input  logic [POIS_W-1:0]   poisson_in_i,
  input  q_t                  spike_current_i,
  input  q_t                  init_value_i,
  input  state_t              old_i,
  input  cfg_t                cfg_i,
  output prod_t               prod_o
);

  logic signed [PROD_W-1:0] raw_mem;
  logic signed [PROD_W-1:0] raw_dc;
  logic signed [PROD_W-1:0] raw_cur;
  logic signed [PROD_W-1:0] raw_cdec;
  prod_t                    prod_d;
  prod_t                    prod_q;

  always_comb begin
    raw_mem  = old_i.membrane * cfg_i.decay_membrane;
    raw_dc   = dc_drive_i * cfg_i.gain_dc;
    raw_cur  = old_i.syn_current * cfg_i.gain_current;
    raw_cdec = old_i.syn_current * cfg_i.decay_current;

    prod_d               = '0;
    prod_d.op            = op_i;
    prod_d.neuron        = neuron_i;
    prod_d.in_range      = in_range_i;
    prod_d.old           = old_i;
    // arithmetic shift floors toward minus infinity
    prod_d.p_mem         = raw_mem >>> FRAC_BITS;
    prod_d.p_dc          = raw_dc >>> FRAC_BITS;
    prod_d.p_cur         = raw_cur >>> FRAC_BITS;
    prod_d.p_cdec        = raw_cdec >>> FRAC_BITS;
    // event count is a plain integer, no shift
    prod_d.p_pois        = $signed({1'b0, poisson_in_i}) * cfg_i.poisson_weight;
    prod_d.spike_current = spike_current_i;
    prod_d.init_value    = init_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: sv/lif_upd.sv
// ----------------------------------------------------------------------------
// lif_upd
// update stage: sums, saturation, threshold test, new state and result register
// ----------------------------------------------------------------------------
module lif_upd import lif_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  prod_t               prod_i,
  input  cfg_t                cfg_i,
  output logic                wr_en_o,
  output state_t              wr_state_o,
  output logic [NEURON_W-1:0] neuron_out_o,
  output logic                spiked_o,
  output q_t                  membrane_out_o
);

  logic signed [SUM_W-1:0] sum_mem;
  logic signed [SUM_W-1:0] sum_cur;
  q_t                      mem_sat;
  q_t                      cur_sat;
  state_t                  new_state;
  logic                    spiked_d;
  q_t                      mem_out_d;
  logic [NEURON_W-1:0]     neuron_q;
  logic                    spiked_q;
  q_t                      mem_out_q;

  always_comb begin
    sum_mem = SUM_W'(prod_i.p_mem) + SUM_W'(prod_i.p_dc) + SUM_W'(prod_i.p_cur);
    sum_cur = SUM_W'(prod_i.p_cdec) + SUM_W'(prod_i.p_pois)
            + SUM_W'(prod_i.spike_current);
    mem_sat = sat_q(sum_mem);
    cur_sat = sat_q(sum_cur);

    new_state = prod_i.old;
    spiked_d  = 1'b0;
    if (prod_i.op == OP_LOAD) begin
      new_state.membrane = prod_i.init_value;
    end else begin
      new_state.syn_current = cur_sat;
      if (prod_i.old.refract_left != '0) begin
        new_state.refract_left = prod_i.old.refract_left - REF_W'(1);
      end else if (mem_sat >= cfg_i.threshold) begin
        spiked_d               = 1'b1;
        new_state.membrane     = '0;
        new_state.refract_left = cfg_i.refractory_ticks;
      end else begin
        new_state.membrane = mem_sat;
      end
    end

    // out-of-range index leaves the store alone and reports zero
    if (!prod_i.in_range) begin
      spiked_d  = 1'b0;
      mem_out_d = '0;
    end else begin
      mem_out_d = new_state.membrane;
    end
  end

  assign wr_en_o    = prod_i.in_range;
  assign wr_state_o = new_state;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neuron_q  <= prod_i.neuron;
      spiked_q  <= spiked_d;
      mem_out_q <= mem_out_d;
    end
  end

  assign neuron_out_o   = neuron_q;
  assign spiked_o       = spiked_q;
  assign membrane_out_o = mem_out_q;

endmodule

FILE: sv/lif_chk.sv
// ----------------------------------------------------------------------------
// lif_chk
// port-level checks of the tick core, bound to the top level
// ----------------------------------------------------------------------------
module lif_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [9:0]            neuron_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [9:0]            neuron_out_o,
  input logic                  spiked_o,
  input logic signed [31:0]    membrane_out_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items accepted and not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(neuron_out_o)
      && $stable(spiked_o) && $stable(membrane_out_o))
    else $error("stalled result changed");

  a_spike_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spiked_o |-> membrane_out_o == 32'sd0)
    else $error("spiking neuron reports nonzero membrane");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 3'd3) && (!out_valid_o || cnt_q != 3'd0))
    else $error("result count out of step with accepted items");

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 in_xfer |-> neuron_i != $past(neuron_i))
    else $error("same neuron accepted in consecutive cycles");

endmodule

bind lif_neuron_tick_update_core lif_chk u_lif_chk (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// LIF tick core check: per-neuron state prediction, scoreboard compare of each
// result transfer, directed corners then random traffic under several configs
// with random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module testbench import lif_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 325;
  localparam int LONG_HOLD       = 120;
  localparam int HOLD_AFTER      = 420;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    op_e                 op;
    logic [NEURON_W-1:0] neuron;
    q_t                  dc;
    logic [POIS_W-1:0]   pois;
    q_t                  scur;
    q_t                  init;
  } tick_item_t;

  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic                spiked;
    q_t                  membrane;
  } tick_result_t;

  class lif_tick_checker;
    cfg_t             cfg;
    q_t               membrane_mem [NEURONS_DEF];
    q_t               current_mem  [NEURONS_DEF];
    logic [REF_W-1:0] refract_mem  [NEURONS_DEF];
    tick_result_t     expected_ticks [$];
    int               mismatches;
    int               results_seen;

    function new();
      cfg = '0;
      mismatches = 0;
      results_seen = 0;
      for (int i = 0; i < NEURONS_DEF; i++) begin
        membrane_mem[i] = '0;
        current_mem[i]  = '0;
        refract_mem[i]  = '0;
      end
    endfunction

    // exact product floored onto the fraction grid
    function longint qmul(q_t a, q_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS_DEF;
    endfunction

    function q_t clip(longint v);
      if (v > longint'(Q_MAX)) begin
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        return Q_MIN;
      end
      return q_t'(v);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DECAY_MEM:   cfg.decay_membrane   = q_t'(data);
        CFG_GAIN_CUR:    cfg.gain_current     = q_t'(data);
        CFG_GAIN_DC:     cfg.gain_dc          = q_t'(data);
        CFG_THRESHOLD:   cfg.threshold        = q_t'(data);
        CFG_REFRACT:     cfg.refractory_ticks = data[REF_W-1:0];
        CFG_DECAY_CUR:   cfg.decay_current    = q_t'(data);
        CFG_POIS_WEIGHT: cfg.poisson_weight   = q_t'(data);
        default: ;
      endcase
    endfunction

    function void note_transfer(tick_item_t it);
      tick_result_t r;
      q_t           cur;
      q_t           x;
      longint       acc;
      int           i;
      i = int'(it.neuron);
      r.neuron = it.neuron;
      r.spiked = 1'b0;
      if (it.op == OP_LOAD) begin
        membrane_mem[i] = it.init;
      end else begin
        // membrane step sees the current from before this tick
        cur = current_mem[i];
        if (refract_mem[i] != '0) begin
          refract_mem[i] = refract_mem[i] - 1'b1;
        end else begin
          acc = qmul(membrane_mem[i], cfg.decay_membrane) + qmul(it.dc, cfg.gain_dc)
              + qmul(cur, cfg.gain_current);
          x = clip(acc);
          if ($signed(x) >= $signed(cfg.threshold)) begin
            r.spiked = 1'b1;
            membrane_mem[i] = '0;
            refract_mem[i] = cfg.refractory_ticks;
          end else begin
            membrane_mem[i] = x;
          end
        end
        acc = qmul(cur, cfg.decay_current)
            + longint'(it.pois) * longint'($signed(cfg.poisson_weight))
            + longint'($signed(it.scur));
        current_mem[i] = clip(acc);
      end
      r.membrane = membrane_mem[i];
      expected_ticks.push_back(r);
    endfunction

    function void check_result(logic [NEURON_W-1:0] neuron, logic spiked, q_t membrane);
      tick_result_t e;
      results_seen++;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: neuron %0d spiked %0b membrane %h",
                   neuron, spiked, membrane);
        end
        return;
      end
      e = expected_ticks.pop_front();
      if (neuron !== e.neuron || spiked !== e.spiked || membrane !== e.membrane) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: neuron exp %0d got %0d, spiked exp %0b got %0b, %s %h got %h",
                   e.neuron, neuron, e.spiked, spiked, "membrane exp", e.membrane,
                   membrane);
        end
      end
    endfunction

    function int outstanding();
      return expected_ticks.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  op_i;
  logic [NEURON_W-1:0]   neuron_i;
  logic signed [Q_W-1:0] dc_drive_i;
  logic [POIS_W-1:0]     poisson_in_i;
  logic signed [Q_W-1:0] spike_current_i;
  logic signed [Q_W-1:0] init_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [NEURON_W-1:0]   neuron_out_o;
  logic                  spiked_o;
  logic signed [Q_W-1:0] membrane_out_o;

  lif_tick_checker chk;
  int              stall_cycles = 0;

  lif_neuron_tick_update_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .neuron_i        (neuron_i),
    .dc_drive_i      (dc_drive_i),
    .poisson_in_i    (poisson_in_i),
    .spike_current_i (spike_current_i),
    .init_value_i    (init_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .neuron_out_o    (neuron_out_o),
    .spiked_o        (spiked_o),
    .membrane_out_o  (membrane_out_o)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  function automatic bit hit(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic q_t q_between(int lo, int hi);
    return q_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic tick_item_t mk(op_e op, int n, q_t dc, int pois, q_t scur, q_t init);
    tick_item_t it;
    it.op     = op;
    it.neuron = NEURON_W'(n);
    it.dc     = dc;
    it.pois   = POIS_W'(pois);
    it.scur   = scur;
    it.init   = init;
    return it;
  endfunction

  // small neuron pool so state gets revisited and back-to-back hazards occur
  function automatic tick_item_t rand_item(int wild_pct);
    tick_item_t it;
    it.op     = hit(8) ? OP_LOAD : OP_TICK;
    it.neuron = hit(20) ? NEURON_W'($urandom) : NEURON_W'($urandom_range(0, 7));
    it.dc     = hit(wild_pct) ? q_t'($urandom) : q_between(-(2 << 16), 5 << 16);
    it.pois   = hit(wild_pct) ? POIS_W'($urandom) : POIS_W'($urandom_range(0, 4));
    it.scur   = hit(wild_pct) ? q_t'($urandom) : q_between(-(1 << 16), 2 << 16);
    it.init   = hit(wild_pct) ? q_t'($urandom) : q_between(-(2 << 16), 3 << 16);
    return it;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    chk.set_reg(idx, data);
  endtask

  task automatic program_regs(q_t dm, q_t gc, q_t gd, q_t th, logic [CFG_DATA_W-1:0] rt,
                              q_t dcur, q_t pw);
    write_reg(CFG_DECAY_MEM, dm);
    write_reg(CFG_GAIN_CUR, gc);
    write_reg(CFG_GAIN_DC, gd);
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_REFRACT, rt);
    write_reg(CFG_DECAY_CUR, dcur);
    write_reg(CFG_POIS_WEIGHT, pw);
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_tick(tick_item_t it, int gap);
    in_valid_i      <= 1'b1;
    op_i            <= it.op;
    neuron_i        <= it.neuron;
    dc_drive_i      <= it.dc;
    poisson_in_i    <= it.pois;
    spike_current_i <= it.scur;
    init_value_i    <= it.init;
    do @(posedge clk_i); while (!in_ready_o);
    chk.note_transfer(it);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and let every expected result come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (chk.outstanding() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      chk.check_result(neuron_out_o, spiked_o, membrane_out_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL lif_neuron_tick_update_core");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  run_len;
    int  pause;
    bit  held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && chk.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      run_len = hit(10) ? 48 : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      pause = pick_gap();
      if (pause > 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
    end
  end

  initial begin
    tick_item_t corner_items [$];
    int         wild_pct;
    chk = new();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    op_i            <= 1'b0;
    neuron_i        <= '0;
    dc_drive_i      <= '0;
    poisson_in_i    <= '0;
    spike_current_i <= '0;
    init_value_i    <= '0;
    out_ready_i     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 0.9, 1.0, 0.5, 3.0, 2 ticks, 0.75, 0.25
    program_regs(32'sh0000_e666, 32'sh0001_0000, 32'sh0000_8000, 32'sh0003_0000, 2,
                 32'sh0000_c000, 32'sh0000_4000);

    corner_items.push_back(mk(OP_LOAD, 0, 0, 0, 0, 0));
    corner_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
    // saturating spike, then refractory ticks with negative drive
    corner_items.push_back(mk(OP_LOAD, 1023, 0, 0, 0, Q_MAX));
    corner_items.push_back(mk(OP_TICK, 1023, Q_MAX, 255, Q_MAX, 0));
    corner_items.push_back(mk(OP_TICK, 1023, Q_MIN, 0, Q_MIN, 0));
    corner_items.push_back(mk(OP_TICK, 1023, Q_MIN, 0, Q_MIN, 0));
    corner_items.push_back(mk(OP_TICK, 1023, Q_MIN, 0, Q_MIN, 0));
    corner_items.push_back(mk(OP_LOAD, 1023, 0, 0, 0, Q_MIN));
    corner_items.push_back(mk(OP_TICK, 1023, 0, 0, 0, 0));
    // exactly at threshold and one step below
    corner_items.push_back(mk(OP_TICK, 6, 32'sh0006_0000, 0, 0, 0));
    corner_items.push_back(mk(OP_TICK, 7, 32'sh0005_ffff, 0, 0, 0));
    // floor of a small negative product
    corner_items.push_back(mk(OP_TICK, 8, -32'sd1, 0, 0, 0));
    repeat (3) corner_items.push_back(mk(OP_TICK, 9, 32'sh0001_0000, 3, 32'sh0000_8000, 0));
    corner_items.push_back(mk(OP_LOAD, 10, 0, 0, 0, 32'sh0002_8000));
    corner_items.push_back(mk(OP_TICK, 10, 32'sh0000_2000, 1, 0, 0));
    corner_items.push_back(mk(OP_TICK, 10'h2aa, 32'sh5555_5555, 8'haa, 32'shaaaa_aaaa,
                              32'sh5555_5555));
    corner_items.push_back(mk(OP_LOAD, 10'h155, 32'shaaaa_aaaa, 8'h55, 32'sh5555_5555,
                              32'shaaaa_aaaa));
    corner_items.push_back(mk(OP_TICK, 10'h155, 32'shaaaa_aaaa, 8'h55, 32'sh5555_5555, 0));
    foreach (corner_items[i]) begin
      offer_tick(corner_items[i], 0);
    end
    settle();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          wild_pct = 15;
          program_regs(q_between(32'h8000, 32'h10000), q_between(32'h4000, 32'h20000),
                       q_between(32'h4000, 32'h20000), q_between(1 << 15, 6 << 16),
                       $urandom_range(0, 5), q_between(32'h4000, 32'hf000),
                       q_between(0, 32'h10000));
        end
        2: begin
          wild_pct = 40;
          program_regs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'hffff_ffff, Q_MAX, Q_MAX);
        end
        3: begin
          wild_pct = 40;
          program_regs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, Q_MIN, Q_MIN);
        end
        4: begin
          wild_pct = 100;
          program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        end
        default: begin
          wild_pct = 25;
          program_regs(q_between(32'hc000, 32'hffff), q_between(32'h8000, 32'h18000),
                       q_between(32'h8000, 32'h18000), q_between(1 << 16, 4 << 16),
                       $urandom_range(0, 3), q_between(32'h8000, 32'he000),
                       q_between(32'h1000, 32'h8000));
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // every 64 items a stretch without sender gaps
        offer_tick(rand_item(wild_pct), (k % 64 < 16) ? 0 : pick_gap());
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (chk.mismatches == 0 && chk.outstanding() == 0) begin
      $display("PASS lif_neuron_tick_update_core");
    end else begin
      $display("FAIL lif_neuron_tick_update_core");
    end
    $finish;
  end

endmodule

FILE: lif_neuron_tick_update_core.f
sv/lif_pkg.sv
sv/lif_ram.sv
sv/lif_mul.sv
sv/lif_upd.sv
sv/lif_neuron_tick_update_core.sv
sv/lif_chk.sv
tb/testbench.sv
